### hdl/tsc_pkg.sv
// tsc_pkg: shared types and constants of the time string checker
// no dependencies; imported by the scan stage, the final stage and the top level
`default_nettype none

package tsc_pkg;

  // character codes
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // saturation limits
  localparam logic [29:0] FRAC_MAX  = 30'd999999999;
  localparam logic [5:0]  COUNT_MAX = 6'd63;

  // result codes, first error in check order wins
  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_TOO_LONG   = 4'd1,
    ERR_COLON      = 4'd2,
    ERR_RANGE_BAR  = 4'd3,
    ERR_TWO_DASH   = 4'd4,
    ERR_DOT        = 4'd5,
    ERR_SPACE      = 4'd6,
    ERR_BAD_CHAR   = 4'd7,
    ERR_OVER_SIX   = 4'd8,
    ERR_DIGIT_CNT  = 4'd9,
    ERR_BAD_TIME   = 4'd10,
    ERR_FRACTION   = 4'd11,
    ERR_EQUAL_ENDS = 4'd12,
    ERR_REVERSED   = 4'd13
  } err_t;

  // configuration register contents
  typedef struct packed {
    logic       ranges_allowed;
    logic [5:0] max_length;
    logic [5:0] max_length_ranges;
    logic [5:0] max_second;
  } cfg_t;

  // everything the final checks need from one finished text
  typedef struct packed {
    logic             truncated;
    err_t             fatal_code;
    logic             seen_colon;
    logic             in_range;
    logic [1:0][5:0]  digit_count;
    logic [1:0][23:0] bcd;
    logic [1:0][19:0] value;
    logic [1:0][29:0] fraction;
    logic [1:0]       fraction_present;
  } snap_t;

endpackage

`default_nettype wire

### hdl/tsc_if.sv
// tsc_if: handshake channels of the time string checker
// character input, result output and configuration write; no dependencies
`default_nettype none

interface tsc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  modport source (output valid, ch, last, input ready);
  modport sink   (input valid, ch, last, output ready);
endinterface

interface tsc_res_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [3:0] error_code;
  logic       old_format;
  modport source (output valid, valid_res, error_code, old_format, input ready);
  modport sink   (input valid, valid_res, error_code, old_format, output ready);
endinterface

interface tsc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/tsc_scan.sv
// tsc_scan: input register and per-character state update of the time checker
// depends on tsc_pkg and tsc_char_if; hands a snapshot of each finished text on
`default_nettype none

module tsc_scan
  import tsc_pkg::*;
#(
  parameter int LENGTH_LIMIT = 63
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  tsc_char_if.sink   chars,
  output logic       snap_valid,
  output snap_t      snap,
  input  wire logic  snap_take
);

  // input register
  logic       in_valid;
  logic [7:0] in_ch;
  logic       in_last;
  logic       advance;

  // per-text state
  logic       [5:0]  position, position_next;
  logic              in_range, in_range_next;
  logic              in_fraction, in_fraction_next;
  logic              pending_dot, pending_dot_next;
  logic              seen_colon, seen_colon_next;
  logic              truncated, truncated_next;
  err_t              fatal_code, fatal_code_next;
  logic [1:0][5:0]   digit_count, digit_count_next;
  logic [1:0][23:0]  bcd, bcd_next;
  logic [1:0][19:0]  value, value_next;
  logic [1:0][29:0]  fraction, fraction_next;
  logic [1:0]        fraction_present, fraction_present_next;

  logic [5:0]  limit_sel;
  logic [5:0]  limit;

  // a last character may only go through when the snapshot slot frees up
  assign advance     = in_valid && (!in_last || !snap_valid || snap_take);
  assign chars.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
    if (chars.valid && chars.ready) begin
      in_ch   <= chars.ch;
      in_last <= chars.last;
    end
  end

  // character limit, capped by the build-time maximum
  assign limit_sel = cfg.ranges_allowed ? cfg.max_length_ranges : cfg.max_length;
  assign limit     = (int'(limit_sel) > LENGTH_LIMIT) ? 6'(LENGTH_LIMIT) : limit_sel;

  // next state for the character in the input register
  always_comb begin
    logic        t;
    logic        is_digit;
    logic [3:0]  d;
    logic        last_counted;
    logic [33:0] frac_calc;
    logic        dot_failed;

    position_next         = position;
    in_range_next         = in_range;
    in_fraction_next      = in_fraction;
    pending_dot_next      = pending_dot;
    seen_colon_next       = seen_colon;
    truncated_next        = truncated;
    fatal_code_next       = fatal_code;
    digit_count_next      = digit_count;
    bcd_next              = bcd;
    value_next            = value;
    fraction_next         = fraction;
    fraction_present_next = fraction_present;

    t            = in_range;
    is_digit     = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);
    d            = 4'(in_ch - CH_ZERO);
    last_counted = in_last || (6'(position + 6'd1) == limit);
    frac_calc    = {4'b0, fraction[t]} * 34'd10 + 34'(d);
    dot_failed   = 1'b0;

    if (position >= limit) begin
      // past the limit: only the dot lookahead still matters
      truncated_next = 1'b1;
      if (pending_dot) begin
        pending_dot_next = 1'b0;
        if (!is_digit && fatal_code == ERR_NONE) fatal_code_next = ERR_DOT;
      end
    end else begin
      position_next = 6'(position + 6'd1);
      if (fatal_code == ERR_NONE) begin
        if (pending_dot) begin
          pending_dot_next = 1'b0;
          if (!is_digit) begin
            fatal_code_next = ERR_DOT;
            dot_failed      = 1'b1;
          end
        end
        if (!dot_failed) begin
          if (is_digit) begin
            if (in_fraction) begin
              // fraction saturates at FRAC_MAX, the largest nine-digit value
              fraction_next[t] = (frac_calc > 34'(FRAC_MAX)) ? FRAC_MAX : frac_calc[29:0];
              fraction_present_next[t] = 1'b1;
            end else begin
              if (digit_count[t] < 6'd6) begin
                bcd_next[t]   = {bcd[t][19:0], d};
                value_next[t] = 20'(value[t] * 20'd10 + 20'(d));
              end
              if (digit_count[t] != COUNT_MAX) begin
                digit_count_next[t] = 6'(digit_count[t] + 6'd1);
              end
            end
          end else begin
            case (in_ch)
              CH_COLON: begin
                if (in_fraction || digit_count[t] == 6'd0) fatal_code_next = ERR_COLON;
                else seen_colon_next = 1'b1;
              end
              CH_DASH: begin
                if (!cfg.ranges_allowed) begin
                  fatal_code_next = ERR_RANGE_BAR;
                end else if (in_range) begin
                  fatal_code_next = ERR_TWO_DASH;
                end else begin
                  in_range_next    = 1'b1;
                  in_fraction_next = 1'b0;
                end
              end
              CH_DOT: begin
                if (in_fraction) begin
                  fatal_code_next = ERR_DOT;
                end else begin
                  pending_dot_next = 1'b1;
                  in_fraction_next = 1'b1;
                end
              end
              CH_SPACE: begin
                // space only as the last checked character at an odd index
                if (!last_counted || !position[0]) fatal_code_next = ERR_SPACE;
              end
              default: fatal_code_next = ERR_BAD_CHAR;
            endcase
          end
        end
      end
    end

    // a dot left hanging at the end of the text
    if (in_last && pending_dot_next && fatal_code_next == ERR_NONE) begin
      fatal_code_next = ERR_DOT;
    end
  end

  // state registers, cleared after each finished text
  always_ff @(posedge clk) begin
    if (rst || (advance && in_last)) begin
      position         <= '0;
      in_range         <= 1'b0;
      in_fraction      <= 1'b0;
      pending_dot      <= 1'b0;
      seen_colon       <= 1'b0;
      truncated        <= 1'b0;
      fatal_code       <= ERR_NONE;
      digit_count      <= '0;
      bcd              <= '0;
      value            <= '0;
      fraction         <= '0;
      fraction_present <= '0;
    end else if (advance) begin
      position         <= position_next;
      in_range         <= in_range_next;
      in_fraction      <= in_fraction_next;
      pending_dot      <= pending_dot_next;
      seen_colon       <= seen_colon_next;
      truncated        <= truncated_next;
      fatal_code       <= fatal_code_next;
      digit_count      <= digit_count_next;
      bcd              <= bcd_next;
      value            <= value_next;
      fraction         <= fraction_next;
      fraction_present <= fraction_present_next;
    end
  end

  // snapshot register toward the final checks
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (advance && in_last) begin
      snap_valid <= 1'b1;
    end else if (snap_take) begin
      snap_valid <= 1'b0;
    end
    if (advance && in_last) begin
      snap.truncated        <= truncated_next;
      snap.fatal_code       <= fatal_code_next;
      snap.seen_colon       <= seen_colon_next;
      snap.in_range         <= in_range_next;
      snap.digit_count      <= digit_count_next;
      snap.bcd              <= bcd_next;
      snap.value            <= value_next;
      snap.fraction         <= fraction_next;
      snap.fraction_present <= fraction_present_next;
    end
  end

endmodule

`default_nettype wire

### hdl/tsc_final.sv
// tsc_final: time field and range checks of a finished text, result register
// depends on tsc_pkg and tsc_res_if; fed by the snapshot of tsc_scan
`default_nettype none

module tsc_final
  import tsc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  snap_valid,
  input  wire snap_t snap,
  output logic       snap_take,
  tsc_res_if.source  results
);

  err_t code;
  logic old;

  // two bcd digits as a number
  function automatic logic [7:0] pair_value(input logic [7:0] b);
    pair_value = 8'(b[7:4] * 8'd10) + 8'(b[3:0]);
  endfunction

  // field checks of one time
  function automatic err_t check_time(input logic [5:0] n, input logic [23:0] b,
                                      input logic fp, input logic [5:0] max_sec);
    logic [7:0] h;
    logic [7:0] m;
    logic [7:0] s;
    h = '0;
    m = '0;
    s = '0;
    if (n == 6'd6) begin
      h = pair_value(b[23:16]);
      m = pair_value(b[15:8]);
      s = pair_value(b[7:0]);
    end else if (n == 6'd4) begin
      h = pair_value(b[15:8]);
      m = pair_value(b[7:0]);
    end else if (n == 6'd2) begin
      h = pair_value(b[7:0]);
    end
    if (n > 6'd6) check_time = ERR_OVER_SIX;
    else if (n[0]) check_time = ERR_DIGIT_CNT;
    else if (h > 8'd23 || m > 8'd59 || s > {2'b0, max_sec}) check_time = ERR_BAD_TIME;
    else if (fp && (n == 6'd2 || n == 6'd4)) check_time = ERR_FRACTION;
    else check_time = ERR_NONE;
  endfunction

  // code selection in check order
  always_comb begin
    err_t c0;
    err_t c1;
    err_t range_code;
    c0 = check_time(snap.digit_count[0], snap.bcd[0], snap.fraction_present[0],
                    cfg.max_second);
    c1 = check_time(snap.digit_count[1], snap.bcd[1], snap.fraction_present[1],
                    cfg.max_second);
    range_code = c0;
    if (snap.in_range && snap.digit_count[1] != 6'd0) begin
      if (range_code == ERR_NONE) range_code = c1;
      if (range_code == ERR_NONE) begin
        if (snap.value[0] == snap.value[1]) begin
          if (snap.fraction[0] == snap.fraction[1]) range_code = ERR_EQUAL_ENDS;
          else if (snap.fraction[0] > snap.fraction[1]) range_code = ERR_REVERSED;
        end else if (snap.value[0] > snap.value[1]) begin
          range_code = ERR_REVERSED;
        end
      end
    end
    if (snap.truncated) code = ERR_TOO_LONG;
    else if (snap.fatal_code != ERR_NONE) code = snap.fatal_code;
    else code = range_code;
    old = (snap.fatal_code == ERR_NONE) && snap.seen_colon;
  end

  assign snap_take = snap_valid && (!results.valid || results.ready);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (snap_take) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
    if (snap_take) begin
      results.valid_res  <= (code == ERR_NONE);
      results.error_code <= code;
      results.old_format <= old;
    end
  end

endmodule

`default_nettype wire

### hdl/dicom_time_string_checker_core.sv
// dicom_time_string_checker_core: top level of the time string checker
// depends on tsc_pkg, tsc_if, tsc_scan and tsc_final; holds the configuration registers
//
// Takes a time text of the form HH[MM[SS[.frac]]], optionally a START-END range,
// one character per transaction with last marking the final one, and gives one
// result per text: pass flag, the first error code and the colon-form flag. A
// character is accepted every clock cycle, except that the last character of a
// text waits while the snapshot register is full and not taken; the per-character
// state update in the scan stage is combinational and sets that rate. The result
// of a text passes through the input register, the snapshot register and the result
// register, and a stalled result holds back only a text's last character while the
// snapshot register is full. Configuration is written through its own channel,
// which is always ready, and should be changed only while no text is in flight.
`default_nettype none

module dicom_time_string_checker_core
  import tsc_pkg::*;
#(
  parameter int LENGTH_LIMIT = 63
) (
  input  wire logic clk,
  input  wire logic rst,
  tsc_char_if.sink  chars,
  tsc_res_if.source results,
  tsc_cfg_if.sink   cfg
);

  // register indexes
  localparam logic [7:0] REG_RANGES_ALLOWED    = 8'd0;
  localparam logic [7:0] REG_MAX_LENGTH        = 8'd1;
  localparam logic [7:0] REG_MAX_LENGTH_RANGES = 8'd2;
  localparam logic [7:0] REG_MAX_SECOND        = 8'd3;

  cfg_t  cfg_regs;
  logic  snap_valid;
  snap_t snap;
  logic  snap_take;

  assign cfg.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.ranges_allowed    <= 1'b0;
      cfg_regs.max_length        <= 6'd16;
      cfg_regs.max_length_ranges <= 6'd28;
      cfg_regs.max_second        <= 6'd60;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_RANGES_ALLOWED:    cfg_regs.ranges_allowed    <= cfg.data[0];
        REG_MAX_LENGTH:        cfg_regs.max_length        <= cfg.data[5:0];
        REG_MAX_LENGTH_RANGES: cfg_regs.max_length_ranges <= cfg.data[5:0];
        REG_MAX_SECOND:        cfg_regs.max_second        <= cfg.data[5:0];
        default: ;
      endcase
    end
  end

  // character scan
  tsc_scan #(
    .LENGTH_LIMIT (LENGTH_LIMIT)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_regs),
    .chars      (chars),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_take  (snap_take)
  );

  // final checks and result
  tsc_final u_final (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_regs),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_take  (snap_take),
    .results    (results)
  );

endmodule

`default_nettype wire

### tb/tsc_tb_pkg.sv
// tsc_tb_pkg: register map of the time string checker as seen by the testbench
// no dependencies; imported by the checker module and the testbench top
`timescale 1ns / 100ps

package tsc_tb_pkg;

  // configuration register indexes
  typedef enum logic [7:0] {
    REG_RANGES_ALLOWED    = 8'd0,
    REG_MAX_LENGTH        = 8'd1,
    REG_MAX_LENGTH_RANGES = 8'd2,
    REG_MAX_SECOND        = 8'd3
  } cfg_reg_t;

  // first index past the mapped registers
  localparam logic [7:0] REG_COUNT = 8'd4;

endpackage

### tb/tsc_checker.sv
// tsc_checker: tracks the time text checker's channels, predicts each verdict and compares
// depends on tsc_pkg, tsc_tb_pkg and the channel interfaces of tsc_if
`timescale 1ns / 100ps

module tsc_checker
  import tsc_pkg::*;
  import tsc_tb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  tsc_char_if       chars,
  tsc_res_if        results,
  tsc_cfg_if        cfg,
  output int        fail_count,
  output int        pending,
  output int        texts_checked
);

  localparam int LENGTH_CAP = 63;

  typedef struct packed {
    logic valid_res;
    err_t code;
    logic old_format;
  } verdict_t;

  // register copies
  logic       cfg_ranges;
  logic [5:0] cfg_max_len;
  logic [5:0] cfg_max_len_rng;
  logic [5:0] cfg_max_sec;

  // scan state of the text in flight
  logic [5:0]  pos;
  logic        in_rng, in_frac, dot_wait, colon_seen, trunc;
  err_t        fatal;
  logic [5:0]  dcount [2];
  logic [23:0] bcd    [2];
  logic [19:0] tval   [2];
  logic [29:0] fval   [2];
  logic        fpres  [2];

  verdict_t verdict_q[$];

  task automatic clear_text();
    pos        = '0;
    in_rng     = 1'b0;
    in_frac    = 1'b0;
    dot_wait   = 1'b0;
    colon_seen = 1'b0;
    trunc      = 1'b0;
    fatal      = ERR_NONE;
    for (int t = 0; t < 2; t++) begin
      dcount[t] = '0;
      bcd[t]    = '0;
      tval[t]   = '0;
      fval[t]   = '0;
      fpres[t]  = 1'b0;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH text %0d: %s got %0d want %0d", texts_checked, what, got, want);
    fail_count++;
  endtask

  // one checked character, inside the length limit and before any fatal error
  task automatic scan_char(logic [7:0] c, logic [5:0] idx, logic last_counted);
    int      t;
    logic    is_dig;
    logic [3:0] d;
    longint  fnext;
    t      = int'(in_rng);
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    d      = c[3:0];
    if (dot_wait) begin
      dot_wait = 1'b0;
      if (!is_dig) begin
        fatal = ERR_DOT;
        return;
      end
    end
    if (is_dig) begin
      if (in_frac) begin
        fnext    = longint'(fval[t]) * 10 + d;
        fval[t]  = (fnext > FRAC_MAX) ? FRAC_MAX : fnext[29:0];
        fpres[t] = 1'b1;
      end else begin
        if (dcount[t] < 6) begin
          bcd[t]  = {bcd[t][19:0], d};
          tval[t] = 20'(tval[t] * 20'd10 + 20'(d));
        end
        if (dcount[t] < COUNT_MAX) dcount[t]++;
      end
      return;
    end
    case (c)
      CH_COLON: begin
        if (in_frac || dcount[t] == 0) fatal = ERR_COLON;
        else colon_seen = 1'b1;
      end
      CH_DASH: begin
        if (!cfg_ranges) fatal = ERR_RANGE_BAR;
        else if (in_rng) fatal = ERR_TWO_DASH;
        else begin
          in_rng  = 1'b1;
          in_frac = 1'b0;
        end
      end
      CH_DOT: begin
        if (in_frac) fatal = ERR_DOT;
        else begin
          dot_wait = 1'b1;
          in_frac  = 1'b1;
        end
      end
      // space only as the last checked character at an odd index
      CH_SPACE: begin
        if (!last_counted || !idx[0]) fatal = ERR_SPACE;
      end
      default: fatal = ERR_BAD_CHAR;
    endcase
  endtask

  function automatic int bcd_pair(logic [23:0] b, int nib);
    return int'(b[4*nib+4 +: 4]) * 10 + int'(b[4*nib +: 4]);
  endfunction

  function automatic err_t time_code(int t);
    int n, h, m, s;
    n = int'(dcount[t]);
    h = 0;
    m = 0;
    s = 0;
    if (n > 6) return ERR_OVER_SIX;
    if (n % 2 != 0) return ERR_DIGIT_CNT;
    if (n == 6) begin
      h = bcd_pair(bcd[t], 4);
      m = bcd_pair(bcd[t], 2);
      s = bcd_pair(bcd[t], 0);
    end else if (n == 4) begin
      h = bcd_pair(bcd[t], 2);
      m = bcd_pair(bcd[t], 0);
    end else if (n == 2) begin
      h = bcd_pair(bcd[t], 0);
    end
    if (h > 23 || m > 59 || s > int'(cfg_max_sec)) return ERR_BAD_TIME;
    if (fpres[t] && (n == 2 || n == 4)) return ERR_FRACTION;
    return ERR_NONE;
  endfunction

  // end-of-text checks: both times, then start before end
  function automatic err_t text_code();
    err_t code, c2;
    code = time_code(0);
    if (in_rng && dcount[1] > 0) begin
      c2 = time_code(1);
      if (code == ERR_NONE) code = c2;
      if (code == ERR_NONE) begin
        if (tval[0] == tval[1]) begin
          if (fval[0] == fval[1]) code = ERR_EQUAL_ENDS;
          else if (fval[0] > fval[1]) code = ERR_REVERSED;
        end else if (tval[0] > tval[1]) begin
          code = ERR_REVERSED;
        end
      end
    end
    return code;
  endfunction

  always @(posedge clk) begin : monitor
    int         limit;
    logic [5:0] idx;
    err_t       code;
    verdict_t   want;
    if (rst) begin
      cfg_ranges      = 1'b0;
      cfg_max_len     = 6'd16;
      cfg_max_len_rng = 6'd28;
      cfg_max_sec     = 6'd60;
      clear_text();
      verdict_q.delete();
      fail_count    = 0;
      texts_checked = 0;
    end else begin
      // register write transaction
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_RANGES_ALLOWED:    cfg_ranges      = cfg.data[0];
          REG_MAX_LENGTH:        cfg_max_len     = cfg.data[5:0];
          REG_MAX_LENGTH_RANGES: cfg_max_len_rng = cfg.data[5:0];
          REG_MAX_SECOND:        cfg_max_sec     = cfg.data[5:0];
          default: ;
        endcase
      end

      // character transaction
      if (chars.valid && chars.ready) begin
        limit = cfg_ranges ? int'(cfg_max_len_rng) : int'(cfg_max_len);
        if (limit > LENGTH_CAP) limit = LENGTH_CAP;
        if (int'(pos) >= limit) begin
          // past the limit: only the dot lookahead still counts
          trunc = 1'b1;
          if (dot_wait) begin
            dot_wait = 1'b0;
            if (!(chars.ch >= CH_ZERO && chars.ch <= CH_NINE) && fatal == ERR_NONE)
              fatal = ERR_DOT;
          end
        end else begin
          idx = pos;
          pos = pos + 6'd1;
          if (fatal == ERR_NONE)
            scan_char(chars.ch, idx, chars.last || (int'(pos) == limit));
        end
        if (chars.last) begin
          if (dot_wait && fatal == ERR_NONE) fatal = ERR_DOT;
          if (trunc) code = ERR_TOO_LONG;
          else if (fatal != ERR_NONE) code = fatal;
          else code = text_code();
          want.valid_res  = (code == ERR_NONE);
          want.code       = code;
          want.old_format = (fatal == ERR_NONE) && colon_seen;
          verdict_q.push_back(want);
          clear_text();
        end
      end

      // result transaction against the oldest prediction
      if (results.valid && results.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result with no text pending, error_code", results.error_code, -1);
        end else begin
          want = verdict_q.pop_front();
          texts_checked++;
          if (results.valid_res !== want.valid_res)
            report_mismatch("valid_res", results.valid_res, want.valid_res);
          if (results.error_code !== want.code)
            report_mismatch("error_code", results.error_code, want.code);
          if (results.old_format !== want.old_format)
            report_mismatch("old_format", results.old_format, want.old_format);
        end
      end
    end
    pending = verdict_q.size();
  end

endmodule

### tb/tb.sv
// tb: stimulus and verdict for dicom_time_string_checker_core
// depends on tsc_pkg, tsc_if, tsc_tb_pkg, tsc_checker and the block itself
`timescale 1ns / 100ps

module tb;
  import tsc_pkg::*;
  import tsc_tb_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_CHARS = 480;
  localparam int PHASES       = 8;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #(CLK_PERIOD / 2) clk = ~clk;

  tsc_char_if chars ();
  tsc_res_if  results ();
  tsc_cfg_if  cfg ();

  dicom_time_string_checker_core dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .results (results),
    .cfg     (cfg)
  );

  int fail_count, pending, texts_checked;

  tsc_checker chk (
    .clk           (clk),
    .rst           (rst),
    .chars         (chars),
    .results       (results),
    .cfg           (cfg),
    .fail_count    (fail_count),
    .pending       (pending),
    .texts_checked (texts_checked)
  );

  // idle patterns: none, sender, receiver, both
  int sender_pct_of [4] = '{0, 66, 0, 33};
  int stall_pct_of  [4] = '{0, 0, 66, 33};
  int sender_idle_pct = 0;
  int stall_pct = 0;

  int chars_sent = 0;
  int cfg_writes = 0;
  logic cur_ranges = 1'b0;
  logic [7:0] txt[$];

  // transactions seen at the last rising edge
  logic char_fire = 1'b0;
  logic cfg_fire  = 1'b0;
  always @(posedge clk) begin
    char_fire <= chars.valid && chars.ready;
    cfg_fire  <= cfg.valid && cfg.ready;
  end

  // receiver stalls
  always @(negedge clk) begin
    results.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic put_char(logic [7:0] c, logic l);
    while ($urandom_range(99) < sender_idle_pct) begin
      chars.valid <= 1'b0;
      chars.ch    <= 8'($urandom);
      chars.last  <= 1'($urandom);
      @(negedge clk);
    end
    chars.valid <= 1'b1;
    chars.ch    <= c;
    chars.last  <= l;
    do @(negedge clk); while (!char_fire);
    chars_sent++;
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i], i == s.len() - 1);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [7:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(negedge clk); while (!cfg_fire);
    cfg.valid <= 1'b0;
    @(negedge clk);
    cfg_writes++;
  endtask

  // wait for every verdict, then let the pipeline empty
  task automatic settle();
    chars.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_regs(logic r, int ml, int mlr, int ms);
    write_reg(REG_RANGES_ALLOWED, {7'($urandom), r});
    write_reg(REG_MAX_LENGTH, {2'($urandom), 6'(ml)});
    write_reg(REG_MAX_LENGTH_RANGES, {2'($urandom), 6'(mlr)});
    write_reg(REG_MAX_SECOND, {2'($urandom), 6'(ms)});
    cur_ranges = r;
  endtask

  // digit pairs, mostly legal values, with optional colons and fraction
  task automatic add_time(int npairs, bit colons);
    int v;
    for (int p = 0; p < npairs; p++) begin
      if (p > 0 && colons) txt.push_back(CH_COLON);
      case (p)
        0:       v = ($urandom_range(9) == 0) ? $urandom_range(99, 24) : $urandom_range(23);
        1:       v = ($urandom_range(9) == 0) ? $urandom_range(99, 60) : $urandom_range(59);
        default: v = ($urandom_range(9) == 0) ? $urandom_range(99, 61) : $urandom_range(60);
      endcase
      txt.push_back(8'(CH_ZERO + v / 10));
      txt.push_back(8'(CH_ZERO + v % 10));
    end
    if ($urandom_range(99) < 40 && (npairs == 3 || $urandom_range(9) == 0)) begin
      txt.push_back(CH_DOT);
      repeat (($urandom_range(9) == 0) ? $urandom_range(12, 10) : $urandom_range(6, 1))
        txt.push_back(8'(CH_ZERO + $urandom_range(9)));
    end
  endtask

  string plain_texts[$] = '{
    "000000", "235960.999999", "240000", "2360", "12:30:45", "12:", "12-13",
    "1200.5", "12.", "1.x", "120000.1.2", "1234 ", "123 ", "12a", "12\n",
    "1234567", "12345", "000000.9999999999"
  };
  string range_texts[$] = '{
    "1000-1200", "1200-1200", "1200-1000", "120000.5-120000.5",
    "120000.6-120000.5", "10-11-12", "1000-", "235960", "12:00-13:00",
    "235959.9999999999"
  };

  initial begin : stimulus
    int phase, phase_chars, kind, start_len, cut, npairs;
    bit colons;
    logic [7:0] special;
    chars.valid   = 1'b0;
    chars.ch      = '0;
    chars.last    = 1'b0;
    cfg.valid     = 1'b0;
    cfg.index     = '0;
    cfg.data      = '0;
    results.ready = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed texts with reset settings, then with ranges on
    sender_idle_pct = sender_pct_of[3];
    stall_pct       = stall_pct_of[3];
    foreach (plain_texts[i]) send_str(plain_texts[i]);
    settle();
    set_regs(1'b1, 16, 28, 59);
    foreach (range_texts[i]) send_str(range_texts[i]);
    settle();

    // random texts over several register settings and idle patterns
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: set_regs(1'b0, 63, 1, 59);
        1: set_regs(1'b1, 1, 63, 60);
        2: set_regs(1'b0, 1, 28, 60);
        3: set_regs(1'b1, 63, 12, 59);
        default: set_regs(1'($urandom),
                          ($urandom_range(3) == 0) ? $urandom_range(63, 1) : $urandom_range(30, 8),
                          ($urandom_range(3) == 0) ? $urandom_range(63, 1) : $urandom_range(30, 8),
                          $urandom_range(60, 59));
      endcase
      if (phase % 2 == 1) write_reg(8'($urandom_range(255, REG_COUNT)), 8'($urandom));
      sender_idle_pct = sender_pct_of[phase % 4];
      stall_pct       = stall_pct_of[phase % 4];
      phase_chars = 0;
      while (phase_chars < RANDOM_CHARS / PHASES) begin
        txt.delete();
        kind = $urandom_range(99);
        if (kind < 10) begin
          // pure noise
          repeat ($urandom_range(8, 1)) txt.push_back(8'($urandom));
        end else begin
          colons = ($urandom_range(4) == 0);
          npairs = ($urandom_range(19) == 0) ? 0 : $urandom_range(3, 1);
          add_time(npairs, colons);
          if ($urandom_range(99) < (cur_ranges ? 60 : 5)) begin
            start_len = txt.size();
            txt.push_back(CH_DASH);
            if ($urandom_range(4) == 0) begin
              for (int i = 0; i < start_len; i++) txt.push_back(txt[i]);
            end else if ($urandom_range(9) != 0) begin
              add_time($urandom_range(3, 1), colons);
            end
          end
          if ($urandom_range(9) == 0) txt.push_back(CH_SPACE);
          // broken texts: one character replaced, inserted or dropped
          if (kind >= 75 && txt.size() > 0) begin
            case ($urandom_range(8))
              0:       special = CH_COLON;
              1:       special = CH_DASH;
              2:       special = CH_DOT;
              3:       special = CH_SPACE;
              4:       special = CH_NUL;
              5:       special = CH_LF;
              6:       special = CH_CR;
              7:       special = 8'(CH_ZERO + $urandom_range(9));
              default: special = 8'($urandom);
            endcase
            cut = $urandom_range(txt.size() - 1);
            case ($urandom_range(2))
              0:       txt[cut] = special;
              1:       txt.insert(cut, special);
              default: txt.delete(cut);
            endcase
          end
        end
        if (txt.size() == 0) txt.push_back(8'($urandom));
        for (int i = 0; i < txt.size(); i++) put_char(txt[i], i == txt.size() - 1);
        phase_chars += txt.size();
      end
      settle();
    end

    $display("covered %0d texts in %0d characters, %0d register writes", texts_checked,
             chars_sent, cfg_writes);
    $display("settings: %0d random phases plus directed, all four idle patterns", PHASES);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d verdicts outstanding", CYCLE_LIMIT, pending);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
